// ----- sv/bmmn_pkg.sv -----
// ----------------------------------------------------------------------------
// bmmn_pkg
// Shared types and constants of the block min-max normalizer.
// ----------------------------------------------------------------------------
package bmmn_pkg;

   localparam int LEVEL_BITS = 32;
   localparam int DIV_CNT_W  = 6;

   typedef struct packed {
      logic fill_en;
      logic rd_start;
      logic rd_next;
      logic div_start;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic fill_last;
      logic rd_last;
      logic div_done;
      logic out_free;
   } sts_type;

endpackage

// ----- sv/block_minmax_normalizer_unit.sv -----
// ----------------------------------------------------------------------------
// block_minmax_normalizer_unit
// Collects a block of samples, then emits each sample scaled so that the
// block minimum maps to 0 and the block maximum to full scale.
// ----------------------------------------------------------------------------
//   channel   direction  handshake            payload
//   req       in         req_valid/req_ready  req_sample
//   rsp       out        rsp_valid/rsp_ready  rsp_level, rsp_block_end
//
// Samples are taken one per cycle while a block fills.
// Each level passes through operand setup, the serial divider with one
// step per quotient bit, the divider's done flag and output load.
// No sample is taken while a block's results are being computed.
// Output stalls hold the sequencer; the final level may wait while the
// next block fills. Synchronous reset, no clearing pass.
// ----------------------------------------------------------------------------
module block_minmax_normalizer_unit #(
   parameter int BLOCK_SIZE  = 64,
   parameter int SAMPLE_BITS = 12
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [SAMPLE_BITS-1:0]           req_sample,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [bmmn_pkg::LEVEL_BITS-1:0]  rsp_level,
   output logic                             rsp_block_end
);

   bmmn_pkg::cmd_type cmd;
   bmmn_pkg::sts_type sts;

   bmmn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .sts       (sts),
      .cmd       (cmd),
      .req_ready (req_ready)
   );

   bmmn_datapath #(
      .BLOCK_SIZE  (BLOCK_SIZE),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_sample    (req_sample),
      .cmd           (cmd),
      .rsp_ready     (rsp_ready),
      .sts           (sts),
      .rsp_valid     (rsp_valid),
      .rsp_level     (rsp_level),
      .rsp_block_end (rsp_block_end)
   );

endmodule

// ----- sv/bmmn_div.sv -----
// ----------------------------------------------------------------------------
// bmmn_div
// Serial restoring divider, one quotient bit per cycle. The upper dividend
// part must be below the divisor, so the quotient fits LEVEL_BITS.
// ----------------------------------------------------------------------------
module bmmn_div #(
   parameter int SAMPLE_BITS = 12
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [SAMPLE_BITS-1:0]           dividend_hi,
   input  logic [bmmn_pkg::LEVEL_BITS-1:0]  dividend_lo,
   input  logic [SAMPLE_BITS-1:0]           divisor,
   output logic                             done,
   output logic [bmmn_pkg::LEVEL_BITS-1:0]  quotient
);

   logic [SAMPLE_BITS-1:0]          rem_ff, rem_in;
   logic [bmmn_pkg::LEVEL_BITS-1:0] quo_ff, quo_in;
   logic [bmmn_pkg::DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                            done_ff, done_in;
   logic [SAMPLE_BITS:0]            shifted;
   logic [SAMPLE_BITS:0]            trial;
   logic                            ge;

   assign shifted = {rem_ff, quo_ff[bmmn_pkg::LEVEL_BITS-1]};
   assign trial   = shifted - {1'b0, divisor};
   assign ge      = !trial[SAMPLE_BITS];

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = dividend_hi;
         quo_in = dividend_lo;
         cnt_in = bmmn_pkg::DIV_CNT_W'(bmmn_pkg::LEVEL_BITS);
      end else if (cnt_ff != '0) begin
         rem_in  = ge ? trial[SAMPLE_BITS-1:0] : shifted[SAMPLE_BITS-1:0];
         quo_in  = {quo_ff[bmmn_pkg::LEVEL_BITS-2:0], ge};
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == bmmn_pkg::DIV_CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ----- sv/bmmn_datapath.sv -----
// ----------------------------------------------------------------------------
// bmmn_datapath
// Sample store, min/max tracking, operand setup, divider and output register.
// ----------------------------------------------------------------------------
module bmmn_datapath #(
   parameter int BLOCK_SIZE  = 64,
   parameter int SAMPLE_BITS = 12
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [SAMPLE_BITS-1:0]           req_sample,
   input  bmmn_pkg::cmd_type                cmd,
   input  logic                             rsp_ready,
   output bmmn_pkg::sts_type                sts,
   output logic                             rsp_valid,
   output logic [bmmn_pkg::LEVEL_BITS-1:0]  rsp_level,
   output logic                             rsp_block_end
);

   localparam int IDX_W = (BLOCK_SIZE > 1) ? $clog2(BLOCK_SIZE) : 1;
   localparam int NUM_W = SAMPLE_BITS + bmmn_pkg::LEVEL_BITS;

   logic [SAMPLE_BITS-1:0]          store_mem [BLOCK_SIZE];
   logic [SAMPLE_BITS-1:0]          rd_data_ff;
   logic [IDX_W-1:0]                fill_ff, fill_in;
   logic [IDX_W-1:0]                rd_idx_ff, rd_addr;
   logic                            rd_en;
   logic [SAMPLE_BITS-1:0]          min_ff, min_in;
   logic [SAMPLE_BITS-1:0]          max_ff, max_in;
   logic [SAMPLE_BITS-1:0]          span;
   logic [SAMPLE_BITS-1:0]          offset;
   logic [NUM_W-1:0]                numer;
   logic                            div_done;
   logic [bmmn_pkg::LEVEL_BITS-1:0] quotient;
   logic                            valid_ff, valid_in;
   logic [bmmn_pkg::LEVEL_BITS-1:0] level_ff;
   logic                            end_ff;
   logic                            fill_last;
   logic                            rd_last;

   assign fill_last = (fill_ff == IDX_W'(BLOCK_SIZE - 1));
   assign rd_last   = (rd_idx_ff == IDX_W'(BLOCK_SIZE - 1));

   // fill counter and min/max
   always_comb begin
      fill_in = fill_ff;
      min_in  = min_ff;
      max_in  = max_ff;
      if (cmd.fill_en) begin
         fill_in = fill_last ? '0 : fill_ff + 1'b1;
         if (fill_ff == '0) begin
            min_in = req_sample;
            max_in = req_sample;
         end else begin
            if (req_sample < min_ff) min_in = req_sample;
            if (req_sample > max_ff) max_in = req_sample;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         min_ff  <= '0;
         max_ff  <= '0;
      end else begin
         fill_ff <= fill_in;
         min_ff  <= min_in;
         max_ff  <= max_in;
      end
   end

   // store
   assign rd_en   = cmd.rd_start || cmd.rd_next;
   assign rd_addr = cmd.rd_start ? '0 : rd_idx_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (cmd.fill_en) begin
         store_mem[fill_ff] <= req_sample;
      end
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_idx_ff <= '0;
      end else if (rd_en) begin
         rd_idx_ff <= rd_addr;
      end
   end

   // offset * (2^32 - 1) / span
   assign span   = max_ff - min_ff;
   assign offset = rd_data_ff - min_ff;
   assign numer  = {offset, {bmmn_pkg::LEVEL_BITS{1'b0}}} - NUM_W'(offset);

   bmmn_div #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_div (
      .clock       (clock),
      .reset       (reset),
      .start       (cmd.div_start),
      .dividend_hi (numer[NUM_W-1:bmmn_pkg::LEVEL_BITS]),
      .dividend_lo (numer[bmmn_pkg::LEVEL_BITS-1:0]),
      .divisor     (span),
      .done        (div_done),
      .quotient    (quotient)
   );

   // output register
   always_comb begin
      valid_in = valid_ff;
      if (cmd.out_load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         level_ff <= (span == '0) ? '0 : quotient;
         end_ff   <= rd_last;
      end
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign sts.fill_last = fill_last;
   assign sts.rd_last   = rd_last;
   assign sts.div_done  = div_done;
   assign sts.out_free  = !valid_ff || rsp_ready;

   assign rsp_valid     = valid_ff;
   assign rsp_level     = level_ff;
   assign rsp_block_end = end_ff;

endmodule

// ----- sv/bmmn_ctrl.sv -----
// ----------------------------------------------------------------------------
// bmmn_ctrl
// Sequencer: collect a block, then run one division per stored sample.
// ----------------------------------------------------------------------------
module bmmn_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  bmmn_pkg::sts_type sts,
   output bmmn_pkg::cmd_type cmd,
   output logic              req_ready
);

   localparam logic [1:0] ST_COLLECT = 2'd0;
   localparam logic [1:0] ST_LOAD    = 2'd1;
   localparam logic [1:0] ST_DIV     = 2'd2;
   localparam logic [1:0] ST_PUT     = 2'd3;

   logic [1:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_COLLECT: begin
            cmd.fill_en = req_valid;
            if (req_valid && sts.fill_last) begin
               cmd.rd_start = 1'b1;
               state_in     = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            if (sts.div_done) state_in = ST_PUT;
         end
         ST_PUT: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               if (sts.rd_last) begin
                  state_in = ST_COLLECT;
               end else begin
                  cmd.rd_next = 1'b1;
                  state_in    = ST_LOAD;
               end
            end
         end
         default: state_in = ST_COLLECT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_COLLECT;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_COLLECT);

endmodule

// ----- sv/bmmn_checker.sv -----
// ----------------------------------------------------------------------------
// bmmn_checker
// Port-level checks of the normalizer, bound to the top level.
// ----------------------------------------------------------------------------
module bmmn_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [bmmn_pkg::LEVEL_BITS-1:0]  rsp_level,
   input logic                             rsp_block_end
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_level) && $stable(rsp_block_end))
      else $error("rsp item changed while stalled");

   // no sample taken while a block is mid-emission
   a_no_req_mid_block: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_block_end |-> !req_ready)
      else $error("req_ready high during block emission");

   // a level taken without a stall before it is not directly followed by another level
   a_gap_after_level: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_block_end && !$past(rsp_valid && !rsp_ready)
      |=> !rsp_valid)
      else $error("next level appeared too early");

   // a sample never yields a result in the next cycle
   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && req_valid && req_ready |=> !rsp_valid)
      else $error("rsp item appeared right after a sample");

endmodule

bind block_minmax_normalizer_unit bmmn_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_level     (rsp_level),
   .rsp_block_end (rsp_block_end)
);
